// ===== hdl/uhp_pkg.sv =====
// uhp_pkg: types, constants and reason codes for the UDP/IPv4 frame header parser.
// Used by every module under hdl/; depends on nothing.
package uhp_pkg;

  // Width of the frame byte counter; it saturates at its all-ones value.
  localparam int COUNT_WIDTH = 17;

  // Header constants.
  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [3:0]  NIBBLE_MASK      = 4'hF;
  localparam logic [3:0]  IP_VERSION_4     = 4'd4;
  localparam logic [3:0]  IHL_NO_OPTIONS   = 4'd5;
  localparam logic [15:0] UDP_HEADER_BYTES = 16'd8;

  // Byte offsets within the frame.
  localparam logic [COUNT_WIDTH-1:0] POS_ETYPE_HI = COUNT_WIDTH'(12);
  localparam logic [COUNT_WIDTH-1:0] POS_ETYPE_LO = COUNT_WIDTH'(13);
  localparam logic [COUNT_WIDTH-1:0] POS_VER_IHL  = COUNT_WIDTH'(14);
  localparam logic [COUNT_WIDTH-1:0] POS_PROTO    = COUNT_WIDTH'(23);
  localparam logic [COUNT_WIDTH-1:0] POS_SRC_LO   = COUNT_WIDTH'(26);
  localparam logic [COUNT_WIDTH-1:0] POS_SRC_HI   = COUNT_WIDTH'(29);
  localparam logic [COUNT_WIDTH-1:0] POS_DST_LO   = COUNT_WIDTH'(30);
  localparam logic [COUNT_WIDTH-1:0] POS_DST_HI   = COUNT_WIDTH'(33);
  localparam logic [COUNT_WIDTH-1:0] POS_SPORT_HI = COUNT_WIDTH'(34);
  localparam logic [COUNT_WIDTH-1:0] POS_SPORT_LO = COUNT_WIDTH'(35);
  localparam logic [COUNT_WIDTH-1:0] POS_DPORT_HI = COUNT_WIDTH'(36);
  localparam logic [COUNT_WIDTH-1:0] POS_DPORT_LO = COUNT_WIDTH'(37);
  localparam logic [COUNT_WIDTH-1:0] POS_ULEN_HI  = COUNT_WIDTH'(38);
  localparam logic [COUNT_WIDTH-1:0] POS_ULEN_LO  = COUNT_WIDTH'(39);
  // Smallest last byte offset of a frame that is not too short (frames under 42 bytes are short).
  localparam logic [COUNT_WIDTH-1:0] POS_MIN_LAST = COUNT_WIDTH'(41);
  // Payload offset minus UDP header minus one: declared payload fits when
  // udp_length + 33 <= last byte offset.
  localparam logic [COUNT_WIDTH:0]   FIT_BIAS     = (COUNT_WIDTH+1)'(33);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};

  // Verdict codes.
  typedef enum logic [2:0] {
    REASON_OK        = 3'd0,
    REASON_SHORT     = 3'd1,
    REASON_ETYPE     = 3'd2,
    REASON_VERSION   = 3'd3,
    REASON_NOT_UDP   = 3'd4,
    REASON_UDP_LEN   = 3'd5,
    REASON_TRUNCATED = 3'd6
  } reason_t;

  // One frame word moving from the input register into the parser.
  typedef struct packed {
    logic       go;    // word is consumed this cycle
    logic [7:0] data;
    logic       last;
  } step_t;

  // Header fields as captured so far, including the current word.
  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  version_and_length;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] udp_length;
  } fields_t;

endpackage

// ===== hdl/uhp_in_reg.sv =====
// uhp_in_reg: input register for frame words, with stall generation.
// Depends on uhp_pkg (step_t).
module uhp_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  input  logic           advance,
  output uhp_pkg::step_t step
);

  logic       full;
  logic [7:0] data;
  logic       last;
  logic       load;

  // Held word is blocked only while the result side cannot take a verdict.
  assign in_stall = full && !advance;
  assign load     = in_valid && !in_stall;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_byte;
      last <= last_byte;
    end
  end

  assign step.go   = full && advance;
  assign step.data = data;
  assign step.last = last;

endmodule

// ===== hdl/uhp_capture.sv =====
// uhp_capture: frame byte counter and header field capture at fixed offsets.
// Depends on uhp_pkg (step_t, fields_t, offsets).
module uhp_capture (
  input  logic                            clk,
  input  logic                            rst,
  input  uhp_pkg::step_t                  step,
  output uhp_pkg::fields_t                fields_now,
  output logic [uhp_pkg::COUNT_WIDTH-1:0] pos
);

  uhp_pkg::fields_t held;
  logic [7:0]       b;

  assign b = step.data;

  // Fold the current word into the held fields according to its offset
  always_comb begin
    fields_now = held;
    if (pos == uhp_pkg::POS_ETYPE_HI || pos == uhp_pkg::POS_ETYPE_LO) begin
      fields_now.ether_type = {held.ether_type[7:0], b};
    end else if (pos == uhp_pkg::POS_VER_IHL) begin
      fields_now.version_and_length = b;
    end else if (pos == uhp_pkg::POS_PROTO) begin
      fields_now.protocol_number = b;
    end else if (pos >= uhp_pkg::POS_SRC_LO && pos <= uhp_pkg::POS_SRC_HI) begin
      fields_now.source_address = {held.source_address[23:0], b};
    end else if (pos >= uhp_pkg::POS_DST_LO && pos <= uhp_pkg::POS_DST_HI) begin
      fields_now.destination_address = {held.destination_address[23:0], b};
    end else if (pos == uhp_pkg::POS_SPORT_HI || pos == uhp_pkg::POS_SPORT_LO) begin
      fields_now.source_port = {held.source_port[7:0], b};
    end else if (pos == uhp_pkg::POS_DPORT_HI || pos == uhp_pkg::POS_DPORT_LO) begin
      fields_now.destination_port = {held.destination_port[7:0], b};
    end else if (pos == uhp_pkg::POS_ULEN_HI || pos == uhp_pkg::POS_ULEN_LO) begin
      fields_now.udp_length = {held.udp_length[7:0], b};
    end
  end

  // Counter and held fields; everything clears after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      held <= '0;
    end else if (step.go) begin
      if (step.last) begin
        pos  <= '0;
        held <= '0;
      end else begin
        held <= fields_now;
        if (pos != uhp_pkg::COUNT_MAX) begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  // Frame boundary restarts the count
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    step.go && step.last |=> pos == '0)
    else $error("byte counter not cleared after last word");

endmodule

// ===== hdl/uhp_verdict.sv =====
// uhp_verdict: header checks in priority order and the result register.
// Depends on uhp_pkg (fields_t, step_t, reason_t, constants).
module uhp_verdict (
  input  logic                            clk,
  input  logic                            rst,
  input  uhp_pkg::step_t                  step,
  input  uhp_pkg::fields_t                fields_now,
  input  logic [uhp_pkg::COUNT_WIDTH-1:0] pos,
  output logic                            advance,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            frame_ok,
  output logic [2:0]                      reject_reason,
  output logic [31:0]                     source_address,
  output logic [31:0]                     destination_address,
  output logic [15:0]                     source_port,
  output logic [15:0]                     destination_port,
  output logic [15:0]                     payload_length
);

  uhp_pkg::reason_t                reason;
  logic [uhp_pkg::COUNT_WIDTH:0]   fit_sum;
  logic [3:0]                      version;
  logic [3:0]                      ihl;

  assign version = fields_now.version_and_length[7:4];
  assign ihl     = fields_now.version_and_length[3:0] & uhp_pkg::NIBBLE_MASK;
  assign fit_sum = (uhp_pkg::COUNT_WIDTH+1)'(fields_now.udp_length) + uhp_pkg::FIT_BIAS;

  // Result slot free, or being emptied this cycle
  assign advance = !out_valid || !out_stall;

  // Checks in order; the first failure names the reason
  always_comb begin
    priority if (pos < uhp_pkg::POS_MIN_LAST) begin
      reason = uhp_pkg::REASON_SHORT;
    end else if (fields_now.ether_type != uhp_pkg::ETHERTYPE_IPV4) begin
      reason = uhp_pkg::REASON_ETYPE;
    end else if (version != uhp_pkg::IP_VERSION_4 || ihl != uhp_pkg::IHL_NO_OPTIONS) begin
      reason = uhp_pkg::REASON_VERSION;
    end else if (fields_now.protocol_number != uhp_pkg::PROTO_UDP) begin
      reason = uhp_pkg::REASON_NOT_UDP;
    end else if (fields_now.udp_length < uhp_pkg::UDP_HEADER_BYTES) begin
      reason = uhp_pkg::REASON_UDP_LEN;
    end else if (fit_sum > (uhp_pkg::COUNT_WIDTH+1)'(pos)) begin
      reason = uhp_pkg::REASON_TRUNCATED;
    end else begin
      reason = uhp_pkg::REASON_OK;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.go && step.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; fields are zero on a rejected frame
  always_ff @(posedge clk) begin
    if (step.go && step.last) begin
      reject_reason <= reason;
      if (reason == uhp_pkg::REASON_OK) begin
        frame_ok            <= 1'b1;
        source_address      <= fields_now.source_address;
        destination_address <= fields_now.destination_address;
        source_port         <= fields_now.source_port;
        destination_port    <= fields_now.destination_port;
        payload_length      <= fields_now.udp_length - uhp_pkg::UDP_HEADER_BYTES;
      end else begin
        frame_ok            <= 1'b0;
        source_address      <= '0;
        destination_address <= '0;
        source_port         <= '0;
        destination_port    <= '0;
        payload_length      <= '0;
      end
    end
  end

  a_ok_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_ok == (reject_reason == uhp_pkg::REASON_OK))
    else $error("frame_ok disagrees with reject_reason");

  a_reject_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> source_address == '0 && destination_address == '0 &&
      source_port == '0 && destination_port == '0 && payload_length == '0)
    else $error("rejected frame carries non-zero fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !step.go)
    else $error("word consumed while verdict is blocked");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    step.go && step.last |=> out_valid)
    else $error("last word produced no verdict");

endmodule

// ===== hdl/udp_ipv4_frame_header_parser.sv =====
// udp_ipv4_frame_header_parser: Ethernet II / IPv4 / UDP header parser, top level.
// Depends on uhp_pkg, uhp_in_reg, uhp_capture, uhp_verdict.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ------------------------------------------
//   in       in_valid / in_stall  data_byte[7:0], last_byte
//   out      out_valid/out_stall  frame_ok, reject_reason[2:0],
//                                 source_address, destination_address,
//                                 source_port, destination_port, payload_length
//
// One frame word per cycle sustained while no verdict is held by out_stall; a verdict is
// presented once the last word has passed the input register, then the result register.
// The throughput is set by the single capture pass between those registers.
// Synchronous active-high rst clears the counter, captured fields and flags.
// in_stall rises only while a word is held and a verdict waits on out_stall.
module udp_ipv4_frame_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_ok,
  output logic [2:0]  reject_reason,
  output logic [31:0] source_address,
  output logic [31:0] destination_address,
  output logic [15:0] source_port,
  output logic [15:0] destination_port,
  output logic [15:0] payload_length
);

  uhp_pkg::step_t                  step;
  uhp_pkg::fields_t                fields_now;
  logic [uhp_pkg::COUNT_WIDTH-1:0] pos;
  logic                            advance;

  uhp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .advance   (advance),
    .step      (step)
  );

  uhp_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .fields_now (fields_now),
    .pos        (pos)
  );

  uhp_verdict u_verdict (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .fields_now          (fields_now),
    .pos                 (pos),
    .advance             (advance),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .frame_ok            (frame_ok),
    .reject_reason       (reject_reason),
    .source_address      (source_address),
    .destination_address (destination_address),
    .source_port         (source_port),
    .destination_port    (destination_port),
    .payload_length      (payload_length)
  );

endmodule
